>>> hw/rtl/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

	localparam int SPA_W = 7;
	localparam logic [SPA_W-1:0] SPA_RESET = 7'd100;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_SAMPLES_IDX = 1'b0;

	localparam int FIXED_BIT  = 6;
	localparam int BUSY_BIT   = 5;
	localparam int MEMERR_BIT = 2;

	localparam int PRAW_W = 16;
	localparam int TRAW_W = 16;
	localparam int STAT_W = 8;
	localparam int P_W = 19;
	localparam int T_W = 15;

	localparam logic signed [16:0] PRESS_OFFSET = 17'sd16384;
	localparam logic signed [17:0] PRESS_SCALE  = 18'sd100000;
	localparam int PRESS_SHIFT = 15;
	localparam int PROD_W = 35;
	localparam logic signed [PROD_W-1:0] PRESS_ROUND = 35'sd32767;
	localparam logic signed [15:0] TEMP_BASE = 16'(24 * 5 + 5000);

	typedef enum logic [2:0] {
		OUT_ACCUM  = 3'd0,
		OUT_AVG    = 3'd1,
		OUT_BADFIX = 3'd2,
		OUT_BUSY   = 3'd3,
		OUT_MEMERR = 3'd4
	} pfa_outcome_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_ACC,
		ST_DIVP_GO,
		ST_DIVP,
		ST_DIVT_GO,
		ST_DIVT,
		ST_EMIT
	} pfa_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pfa_div_stat_t;

endpackage

>>> hw/rtl/pfa_in_if.sv
`timescale 1ns / 1ps

interface pfa_in_if #(
	parameter int TIME_WIDTH = 48
);
	logic                  valid;
	logic                  ready;
	logic [7:0]            status_byte;
	logic [15:0]           pressure_raw;
	logic [15:0]           temp_code;
	logic [TIME_WIDTH-1:0] timestamp;

	modport source (
		output valid, status_byte, pressure_raw, temp_code, timestamp,
		input  ready
	);

	modport sink (
		input  valid, status_byte, pressure_raw, temp_code, timestamp,
		output ready
	);
endinterface

>>> hw/rtl/pfa_out_if.sv
`timescale 1ns / 1ps

interface pfa_out_if #(
	parameter int TIME_WIDTH = 48
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            outcome;
	logic signed [18:0]    avg_pressure_mbar;
	logic signed [14:0]    avg_temp_centi;
	logic [TIME_WIDTH-1:0] mid_timestamp;

	modport source (
		output valid, outcome, avg_pressure_mbar, avg_temp_centi, mid_timestamp,
		input  ready
	);

	modport sink (
		input  valid, outcome, avg_pressure_mbar, avg_temp_centi, mid_timestamp,
		output ready
	);
endinterface

>>> hw/rtl/pressure_frame_average_top.sv
`timescale 1ns / 1ps

// Pressure frame averager. Each accepted frame beat is checked (fixed bit, busy, memory error,
// in that order) and, if it passes, converted to millibar and centi-degrees and summed; one
// result beat comes out per frame. The frame that completes an average also runs both means
// through one shared restoring divider, one quotient bit per cycle, pressure then temperature;
// its dividend is 19 + clog2(MAX_AVG_COUNT) bits wide. The result beat is loaded into the output
// register from the emit state, which waits only while the previous result is still unaccepted.
// The frame port is ready only while no frame is in work; a finished result waits in the output
// register while the next frame is taken. Writing samples_per_average (APB offset 0) clears the
// running sums.
module pressure_frame_average_top #(
	parameter int MAX_AVG_COUNT = 100,
	parameter int TIME_WIDTH    = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pfa_in_if.sink                        frame,
	pfa_out_if.source                     result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfa_pkg::APB_AW-1:0]    paddr,
	input  logic [pfa_pkg::APB_DW-1:0]    pwdata,
	output logic [pfa_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int CNT_W   = $clog2(MAX_AVG_COUNT + 1);
	localparam int CMP_W   = (CNT_W > pfa_pkg::SPA_W) ? CNT_W : pfa_pkg::SPA_W;
	localparam int P_SUM_W = pfa_pkg::P_W + $clog2(MAX_AVG_COUNT);
	localparam int T_SUM_W = pfa_pkg::T_W + $clog2(MAX_AVG_COUNT);
	localparam int DIV_W   = P_SUM_W;

	pfa_pkg::pfa_state_t state_q, state_d;

	logic [pfa_pkg::SPA_W-1:0] spa;
	logic                      cfg_wr;

	logic [pfa_pkg::STAT_W-1:0] status_q;
	logic [pfa_pkg::PRAW_W-1:0] praw_q;
	logic [pfa_pkg::TRAW_W-1:0] traw_q;
	logic [TIME_WIDTH-1:0]      ts_q;

	logic signed [pfa_pkg::PROD_W-1:0] prod_s1;
	logic signed [pfa_pkg::T_W-1:0]    t_s1;
	logic signed [pfa_pkg::P_W-1:0]    p_s2;
	logic signed [pfa_pkg::T_W-1:0]    t_s2;

	logic signed [P_SUM_W-1:0] ptot_q;
	logic signed [T_SUM_W-1:0] ttot_q;
	logic [CNT_W-1:0]          tally_q;
	logic [TIME_WIDTH-1:0]     mid_q;
	logic                      last_q;

	pfa_pkg::pfa_outcome_t     outcome_q;
	logic signed [pfa_pkg::P_W-1:0] pm_q;
	logic signed [pfa_pkg::T_W-1:0] tm_q;

	logic                           out_valid_q;
	pfa_pkg::pfa_outcome_t          out_outcome_q;
	logic signed [pfa_pkg::P_W-1:0] out_p_q;
	logic signed [pfa_pkg::T_W-1:0] out_t_q;
	logic [TIME_WIDTH-1:0]          out_ts_q;

	logic [CMP_W-1:0] spa_ext;
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] tally_nx;
	logic [CNT_W:0]   half_n;

	logic signed [16:0]                p_off;
	logic signed [pfa_pkg::PROD_W-1:0] prod;
	logic signed [pfa_pkg::PROD_W-1:0] prod_adj;
	logic signed [15:0]                t_wide;

	logic                   pneg, tneg;
	logic [P_SUM_W-1:0]     pmag;
	logic [T_SUM_W-1:0]     tmag;
	logic                   div_start;
	logic [DIV_W-1:0]       div_dividend;
	logic [DIV_W-1:0]       div_q;
	logic [DIV_W-1:0]       div_signed;
	pfa_pkg::pfa_div_stat_t div_stat;

	logic frame_acc;
	logic out_free;

	pfa_apb_regs u_regs (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.samples_per_average (spa),
		.cfg_wr              (cfg_wr)
	);

	pfa_divider #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (n_eff),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// effective frame count
	assign spa_ext = CMP_W'(spa);
	assign n_eff   = (spa == '0 || spa_ext > CMP_W'(MAX_AVG_COUNT)) ?
	                 CNT_W'(MAX_AVG_COUNT) : CNT_W'(spa_ext);
	assign tally_nx = tally_q + 1'b1;
	assign half_n   = ((CNT_W + 1)'(n_eff) + 1'b1) >> 1;

	// conversion arithmetic
	assign p_off    = $signed({1'b0, praw_q}) - pfa_pkg::PRESS_OFFSET;
	assign prod     = p_off * pfa_pkg::PRESS_SCALE;
	assign t_wide   = $signed({2'b00, traw_q[15:4], 2'b00}) + $signed({4'b0000, traw_q[15:4]})
	                  - pfa_pkg::TEMP_BASE;
	assign prod_adj = prod_s1 + (prod_s1[pfa_pkg::PROD_W-1] ? pfa_pkg::PRESS_ROUND : '0);

	// divider operands and signs
	assign pneg = ptot_q[P_SUM_W-1];
	assign tneg = ttot_q[T_SUM_W-1];
	assign pmag = pneg ? P_SUM_W'(-ptot_q) : P_SUM_W'(ptot_q);
	assign tmag = tneg ? T_SUM_W'(-ttot_q) : T_SUM_W'(ttot_q);
	assign div_dividend = (state_q == pfa_pkg::ST_DIVT_GO) ? DIV_W'(tmag) : pmag;
	assign div_signed   = (((state_q == pfa_pkg::ST_DIVT) ? tneg : pneg)) ? -div_q : div_q;

	assign frame_acc = frame.valid && frame.ready;
	assign out_free  = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		frame.ready = 1'b0;
		div_start   = 1'b0;
		unique case (state_q)
			pfa_pkg::ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					state_d = pfa_pkg::ST_MUL;
				end
			end
			pfa_pkg::ST_MUL: begin
				if (!status_q[pfa_pkg::FIXED_BIT] || status_q[pfa_pkg::BUSY_BIT] ||
				    status_q[pfa_pkg::MEMERR_BIT]) begin
					state_d = pfa_pkg::ST_EMIT;
				end else begin
					state_d = pfa_pkg::ST_SCALE;
				end
			end
			pfa_pkg::ST_SCALE: begin
				state_d = pfa_pkg::ST_ACC;
			end
			pfa_pkg::ST_ACC: begin
				state_d = last_q ? pfa_pkg::ST_DIVP_GO : pfa_pkg::ST_EMIT;
			end
			pfa_pkg::ST_DIVP_GO: begin
				div_start = 1'b1;
				state_d   = pfa_pkg::ST_DIVP;
			end
			pfa_pkg::ST_DIVP: begin
				if (div_stat.done) begin
					state_d = pfa_pkg::ST_DIVT_GO;
				end
			end
			pfa_pkg::ST_DIVT_GO: begin
				div_start = 1'b1;
				state_d   = pfa_pkg::ST_DIVT;
			end
			pfa_pkg::ST_DIVT: begin
				if (div_stat.done) begin
					state_d = pfa_pkg::ST_EMIT;
				end
			end
			pfa_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = pfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfa_pkg::ST_IDLE;
			end
		endcase
	end

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptot_q  <= '0;
			ttot_q  <= '0;
			tally_q <= '0;
			mid_q   <= '0;
		end else if (cfg_wr) begin
			ptot_q  <= '0;
			ttot_q  <= '0;
			tally_q <= '0;
		end else if (state_q == pfa_pkg::ST_ACC) begin
			ptot_q  <= ptot_q + P_SUM_W'(p_s2);
			ttot_q  <= ttot_q + T_SUM_W'(t_s2);
			tally_q <= tally_nx;
			if ((CNT_W + 1)'(tally_nx) == half_n) begin
				mid_q <= ts_q;
			end
		end else if (state_q == pfa_pkg::ST_EMIT && out_free &&
		             outcome_q == pfa_pkg::OUT_AVG) begin
			ptot_q  <= '0;
			ttot_q  <= '0;
			tally_q <= '0;
		end
	end

	// frame and datapath registers
	always_ff @(posedge clk) begin
		if (frame_acc) begin
			status_q <= frame.status_byte;
			praw_q   <= frame.pressure_raw;
			traw_q   <= frame.temp_code;
			ts_q     <= frame.timestamp;
		end
		unique case (state_q)
			pfa_pkg::ST_MUL: begin
				prod_s1 <= prod;
				t_s1    <= t_wide[pfa_pkg::T_W-1:0];
				if (!status_q[pfa_pkg::FIXED_BIT]) begin
					outcome_q <= pfa_pkg::OUT_BADFIX;
				end else if (status_q[pfa_pkg::BUSY_BIT]) begin
					outcome_q <= pfa_pkg::OUT_BUSY;
				end else if (status_q[pfa_pkg::MEMERR_BIT]) begin
					outcome_q <= pfa_pkg::OUT_MEMERR;
				end else begin
					outcome_q <= pfa_pkg::OUT_ACCUM;
				end
			end
			pfa_pkg::ST_SCALE: begin
				p_s2   <= prod_adj[pfa_pkg::PRESS_SHIFT +: pfa_pkg::P_W];
				t_s2   <= t_s1;
				last_q <= (tally_nx >= n_eff);
			end
			pfa_pkg::ST_ACC: begin
				if (last_q) begin
					outcome_q <= pfa_pkg::OUT_AVG;
				end
			end
			pfa_pkg::ST_DIVP: begin
				if (div_stat.done) begin
					pm_q <= div_signed[pfa_pkg::P_W-1:0];
				end
			end
			pfa_pkg::ST_DIVT: begin
				if (div_stat.done) begin
					tm_q <= div_signed[pfa_pkg::T_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pfa_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfa_pkg::ST_EMIT && out_free) begin
			out_outcome_q <= outcome_q;
			if (outcome_q == pfa_pkg::OUT_AVG) begin
				out_p_q  <= pm_q;
				out_t_q  <= tm_q;
				out_ts_q <= mid_q;
			end else begin
				out_p_q  <= '0;
				out_t_q  <= '0;
				out_ts_q <= '0;
			end
		end
	end

	assign result.valid             = out_valid_q;
	assign result.outcome           = out_outcome_q;
	assign result.avg_pressure_mbar = out_p_q;
	assign result.avg_temp_centi    = out_t_q;
	assign result.mid_timestamp     = out_ts_q;

endmodule

>>> hw/rtl/pfa_apb_regs.sv
`timescale 1ns / 1ps

module pfa_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfa_pkg::APB_AW-1:0]    paddr,
	input  logic [pfa_pkg::APB_DW-1:0]    pwdata,
	output logic [pfa_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output logic [pfa_pkg::SPA_W-1:0]     samples_per_average,
	output logic                          cfg_wr
);

	logic [pfa_pkg::SPA_W-1:0] spa_q;
	logic                      hit;

	assign pready = 1'b1;
	assign hit    = (paddr[pfa_pkg::APB_AW-1] == pfa_pkg::REG_SAMPLES_IDX);
	assign cfg_wr = psel && penable && pwrite && pready && hit;
	assign samples_per_average = spa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spa_q <= pfa_pkg::SPA_RESET;
		end else if (cfg_wr) begin
			spa_q <= pwdata[pfa_pkg::SPA_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = pfa_pkg::APB_DW'(spa_q);
		end
	end

endmodule

>>> hw/rtl/pfa_divider.sv
`timescale 1ns / 1ps

module pfa_divider #(
	parameter int DIVIDEND_W = 25,
	parameter int DIVISOR_W  = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DIVIDEND_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0]      divisor,
	output pfa_pkg::pfa_div_stat_t    stat,
	output logic [DIVIDEND_W-1:0]     quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;

	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = !diff[DIVISOR_W];

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

endmodule
